@@ hw/rtl/fcca_pkg.sv @@
// shared types and constants of the fat12 cluster chain allocator
// no dependencies; imported by the sequencer, register block, top level and checker
package fcca_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 4096;
  localparam int unsigned CW              = 12;

  localparam logic [CW-1:0] END_MARK  = 12'hFFF;
  localparam logic [3:0]    MEDIA_HI  = 4'hF;
  localparam logic [CW-1:0] DCC_RST   = 12'd354;
  localparam logic [7:0]    MEDIA_RST = 8'd253;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_COUNT = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOCONTIG = 2'd2;

  localparam logic REG_DCC   = 1'b0;
  localparam logic REG_MEDIA = 1'b1;

  typedef struct packed {
    logic [1:0]    action;
    logic [CW-1:0] cluster_count;
    logic          need_contiguous;
    logic [CW-1:0] entry_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [CW-1:0] chain_head;
    logic [CW-1:0] entry_value;
    logic [CW-1:0] used_count;
  } rsp_t;

  typedef struct packed {
    logic [CW-1:0] data_cluster_count;
    logic [7:0]    media_code;
  } cfg_t;

endpackage

@@ hw/rtl/fcca_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies
module fcca_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/fcca_regs.sv @@
// apb configuration registers: data cluster count and media code
// depends on fcca_pkg
module fcca_regs (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output fcca_pkg::cfg_t cfg
);
  import fcca_pkg::*;

  logic wr;

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_cluster_count <= DCC_RST;
      cfg.media_code         <= MEDIA_RST;
    end else if (wr) begin
      unique case (paddr[2])
        REG_DCC: begin
          cfg.data_cluster_count <= pwdata[CW-1:0];
        end
        REG_MEDIA: begin
          cfg.media_code <= pwdata[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DCC:   prdata = {{(32-CW){1'b0}}, cfg.data_cluster_count};
      REG_MEDIA: prdata = {24'd0, cfg.media_code};
      default:   prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/fcca_seq.sv @@
// sequencer with the shared scan pointer, limit compare and free test
// depends on fcca_pkg; drives the table ram ports
module fcca_seq #(
  parameter int unsigned TABLE_DEPTH = fcca_pkg::DEF_TABLE_DEPTH,
  localparam int unsigned AW         = $clog2(TABLE_DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  fcca_pkg::cmd_t          cmd,
  input  fcca_pkg::cfg_t          cfg,
  output logic                    busy,
  output logic                    done,
  output fcca_pkg::rsp_t          rsp,
  output logic                    we,
  output logic [AW-1:0]           waddr,
  output logic [fcca_pkg::CW-1:0] wdata,
  output logic [AW-1:0]           raddr,
  input  logic [fcca_pkg::CW-1:0] rdata
);
  import fcca_pkg::*;

  localparam int unsigned PW = AW + 1;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_TEST  = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;
  localparam logic [2:0] S_RDA   = 3'd5;
  localparam logic [2:0] S_RDD   = 3'd6;

  logic [2:0]    state;
  logic [PW-1:0] ptr;
  logic [AW-1:0] prev;
  logic [AW-1:0] first;
  logic          prev_valid;
  logic [CW-1:0] left;
  logic [CW-1:0] used;
  logic          is_count;
  logic          contig;
  logic          clr_reply;

  logic [CW:0]   lim_full;
  logic [PW-1:0] lim;
  logic          at_lim;
  logic [PW-1:0] ptr_inc;
  logic [AW-1:0] cur;
  logic          adj;
  logic          free;
  logic          idx_ok;
  logic          link_ok;
  logic          rd_direct;
  logic [CW-1:0] rd_value;

  assign lim_full = {1'b0, cfg.data_cluster_count} + (CW+1)'(2);
  assign lim      = (lim_full > (CW+1)'(TABLE_DEPTH)) ? PW'(TABLE_DEPTH) : lim_full[PW-1:0];
  assign at_lim   = ptr >= lim;
  assign ptr_inc  = ptr + PW'(1);
  assign cur      = ptr[AW-1:0];
  assign adj      = ptr == ({1'b0, prev} + PW'(1));
  assign free     = rdata == '0;
  assign idx_ok   = {1'b0, cmd.entry_index} < (CW+1)'(TABLE_DEPTH);
  assign link_ok  = !contig || adj;
  assign busy     = state != S_IDLE;
  assign raddr    = cur;

  // reserved and out-of-range entries answer without the table
  always_comb begin
    rd_direct = 1'b1;
    rd_value  = '0;
    if (cmd.entry_index == CW'(0)) begin
      rd_value = {MEDIA_HI, cfg.media_code};
    end else if (cmd.entry_index == CW'(1)) begin
      rd_value = END_MARK;
    end else if (idx_ok) begin
      rd_direct = 1'b0;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = prev;
    wdata = CW'(cur);
    unique case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = cur;
        wdata = '0;
      end
      S_TEST: begin
        we = !is_count && free && prev_valid && link_ok;
      end
      S_END: begin
        we    = 1'b1;
        wdata = END_MARK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      ptr       <= '0;
      clr_reply <= 1'b0;
      done      <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          if (ptr == PW'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
            rsp   <= '0;
            done  <= clr_reply;
          end else begin
            ptr  <= ptr_inc;
            done <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            contig     <= cmd.need_contiguous;
            left       <= cmd.cluster_count;
            prev_valid <= 1'b0;
            used       <= '0;
            is_count   <= cmd.action == ACT_COUNT;
            unique case (cmd.action)
              ACT_ALLOC: begin
                ptr   <= PW'(2);
                rsp   <= '0;
                done  <= cmd.cluster_count == '0;
                state <= (cmd.cluster_count == '0) ? S_IDLE : S_PROBE;
              end
              ACT_READ: begin
                ptr   <= PW'(cmd.entry_index);
                rsp   <= {ST_OK, CW'(0), rd_value, CW'(0)};
                done  <= rd_direct;
                state <= rd_direct ? S_IDLE : S_RDA;
              end
              ACT_COUNT: begin
                ptr   <= PW'(2);
                rsp   <= '0;
                done  <= 1'b0;
                state <= S_PROBE;
              end
              ACT_CLEAR: begin
                ptr       <= '0;
                rsp       <= '0;
                clr_reply <= 1'b1;
                done      <= 1'b0;
                state     <= S_CLR;
              end
              default: begin
                done <= 1'b0;
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        S_PROBE: begin
          if (at_lim) begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (is_count) begin
              rsp.used_count <= used;
            end else begin
              rsp.status <= ST_FULL;
            end
          end else begin
            state <= S_TEST;
            done  <= 1'b0;
          end
        end
        S_TEST: begin
          if (is_count) begin
            if (!free) begin
              used <= used + CW'(1);
            end
            ptr   <= ptr_inc;
            state <= S_PROBE;
            done  <= 1'b0;
          end else if (!free) begin
            ptr   <= ptr_inc;
            state <= S_PROBE;
            done  <= 1'b0;
          end else if (prev_valid && !link_ok) begin
            rsp.status <= ST_NOCONTIG;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            prev       <= cur;
            prev_valid <= 1'b1;
            if (!prev_valid) begin
              first <= cur;
            end
            left  <= left - CW'(1);
            ptr   <= ptr_inc;
            done  <= 1'b0;
            state <= (left == CW'(1)) ? S_END : S_PROBE;
          end
        end
        S_END: begin
          rsp.status     <= ST_OK;
          rsp.chain_head <= CW'(first);
          done           <= 1'b1;
          state          <= S_IDLE;
        end
        S_RDA: begin
          done  <= 1'b0;
          state <= S_RDD;
        end
        S_RDD: begin
          rsp.entry_value <= rdata;
          done            <= 1'b1;
          state           <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/fat12_cluster_chain_allocator_unit.sv @@
// top level of the fat12 cluster chain allocator
// depends on fcca_pkg, fcca_regs, fcca_seq and fcca_ram
//
// A command beat is taken when start is high and busy is low; every command
// gives exactly one result beat on rsp, marked by done for one cycle, which
// the receiver must take as it comes. After reset the table is swept to free
// with busy high. Table reads go through one ram with registered read data,
// addressed by a single scan pointer, so each probed entry passes through a
// probe state and a test state: count scans from cluster 2 up to the limit,
// an allocation from cluster 2 up to the last cluster taken, a table read
// passes through the read address and read data states (the reserved or
// out-of-range entries answer without them), and clear sweeps the table.
module fat12_cluster_chain_allocator_unit #(
  parameter int unsigned TABLE_DEPTH = fcca_pkg::DEF_TABLE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  logic           start,
  input  fcca_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done,
  output fcca_pkg::rsp_t rsp
);
  import fcca_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  cfg_t          cfg;
  logic          we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [CW-1:0] rdata;

  fcca_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fcca_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .cfg   (cfg),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  fcca_ram #(
    .WIDTH (CW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

@@ hw/rtl/fcca_chk.sv @@
// port-level checker for the fat12 cluster chain allocator, bound to the top level
// depends on fcca_pkg and fat12_cluster_chain_allocator_unit
module fcca_chk (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input fcca_pkg::rsp_t rsp
);
  import fcca_pkg::*;

  // a result beat is only shown once the unit is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // an accepted command either starts work or answers at once
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither started nor answered");

  // a failed allocation never names a first cluster
  a_fail_no_first: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> (rsp.chain_head == '0))
    else $error("failed allocation reports a first cluster");

  // the table sweep after reset keeps the unit busy
  a_reset_sweep: assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("not busy after reset");

endmodule

bind fat12_cluster_chain_allocator_unit fcca_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

@@ tb/testbench.sv @@
// self-checking testbench for fat12_cluster_chain_allocator_unit
// a shadow copy of the cluster table predicts every result beat
// depends on fcca_pkg and the rtl of the unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fcca_pkg::*;

  localparam int QUIET_LIMIT = 60000;

  class fat_shadow;
    logic [CW-1:0] fat [0:DEF_TABLE_DEPTH-1];
    logic [CW-1:0] dcc;
    logic [7:0]    media;
    rsp_t          expected_rsp [$];
    int            errors;

    function new();
      foreach (fat[i]) fat[i] = '0;
      dcc = DCC_RST;
      media = MEDIA_RST;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] val);
      if (idx == REG_DCC) dcc = val[CW-1:0];
      else media = val[7:0];
    endfunction

    function int unsigned scan_end();
      int unsigned e;
      e = dcc + 2;
      if (e > DEF_TABLE_DEPTH) e = DEF_TABLE_DEPTH;
      return e;
    endfunction

    function int unsigned next_free(int unsigned from);
      int unsigned c;
      for (c = from; c < scan_end(); c++)
        if (fat[c] == '0) return c;
      return 0;
    endfunction

    function int outstanding();
      return expected_rsp.size();
    endfunction

    function void accept_cmd(cmd_t c);
      rsp_t          r;
      int unsigned   lim, head, prev, cur, n, used;
      logic          stop;
      r = '0;
      lim = scan_end();
      case (c.action)
        ACT_ALLOC: begin
          if (c.cluster_count != '0) begin
            head = next_free(2);
            if (head == 0) begin
              r.status = ST_FULL;
            end else begin
              r.status = ST_OK;
              prev = 0;
              cur = head;
              stop = 1'b0;
              for (n = 0; n < c.cluster_count && !stop; n++) begin
                if (cur == 0 || cur >= lim) begin
                  r.status = ST_FULL;
                  stop = 1'b1;
                end else if (c.need_contiguous && n > 0 && cur != head + n) begin
                  r.status = ST_NOCONTIG;
                  stop = 1'b1;
                end else begin
                  if (prev != 0) fat[prev] = CW'(cur);
                  prev = cur;
                  cur = next_free(cur + 1);
                end
              end
              if (r.status == ST_OK) begin
                fat[prev] = END_MARK;
                r.chain_head = CW'(head);
              end
            end
          end
        end
        ACT_READ: begin
          if (c.entry_index == 0) r.entry_value = {MEDIA_HI, media};
          else if (c.entry_index == 1) r.entry_value = END_MARK;
          else r.entry_value = fat[c.entry_index];
        end
        ACT_COUNT: begin
          used = 0;
          for (n = 2; n < lim; n++)
            if (fat[n] != '0) used++;
          r.used_count = CW'(used);
        end
        default: begin
          foreach (fat[i]) fat[i] = '0;
        end
      endcase
      expected_rsp.push_back(r);
    endfunction

    function void field_cmp(string name, logic [CW-1:0] want, logic [CW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_rsp(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        $display("%0t: result beat with nothing pending, expected none got %h", $time, got);
        errors++;
        return;
      end
      want = expected_rsp.pop_front();
      field_cmp("status", {10'd0, want.status}, {10'd0, got.status});
      field_cmp("chain_head", want.chain_head, got.chain_head);
      field_cmp("entry_value", want.entry_value, got.entry_value);
      field_cmp("used_count", want.used_count, got.used_count);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  cmd_t        cmd;
  logic        busy;
  logic        done;
  rsp_t        rsp;

  fat_shadow   shadow;
  int          idle_pct = 0;
  int          quiet = 0;

  fat12_cluster_chain_allocator_unit uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done),
    .rsp     (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) shadow.check_rsp(rsp);
      if (done || (start && !busy)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  function automatic cmd_t mk(logic [1:0] act, logic [CW-1:0] cnt, logic contig,
                              logic [CW-1:0] idx);
    cmd_t c;
    c.action = act;
    c.cluster_count = cnt;
    c.need_contiguous = contig;
    c.entry_index = idx;
    return c;
  endfunction

  function automatic cmd_t rand_cmd(int unsigned span);
    cmd_t        c;
    int unsigned r;
    c.cluster_count = CW'($urandom);
    c.need_contiguous = 1'($urandom_range(1, 0));
    c.entry_index = CW'($urandom);
    r = $urandom_range(99, 0);
    if (r < 45) c.action = ACT_ALLOC;
    else if (r < 75) c.action = ACT_READ;
    else if (r < 96) c.action = ACT_COUNT;
    else c.action = ACT_CLEAR;
    r = $urandom_range(99, 0);
    if (r < 65) c.cluster_count = CW'($urandom_range(6, 0));
    else if (r < 90) c.cluster_count = CW'($urandom_range(span + 3, 0));
    if ($urandom_range(99, 0) < 80) c.entry_index = CW'($urandom_range(span + 3, 0));
    return c;
  endfunction

  task automatic issue(input cmd_t c);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    shadow.accept_cmd(c);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (shadow.outstanding() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers back to back, psel held across the pair
  task automatic configure(input logic [CW-1:0] span, input logic [7:0] mbyte);
    int          i;
    logic        idx;
    logic [31:0] val;
    psel <= 1'b1;
    pwrite <= 1'b1;
    for (i = 0; i < 2; i++) begin
      idx = (i == 0) ? REG_DCC : REG_MEDIA;
      val = (i == 0) ? {20'd0, span} : {24'd0, mbyte};
      paddr <= {idx, 2'b00};
      pwdata <= val;
      penable <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      shadow.write_reg(idx, val);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int          ph;
    int          k;
    int          n_items;
    int unsigned span;
    shadow = new();
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    start <= 1'b0;
    cmd <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // reset settings: reserved entries, chains, partial links on a full disk
    issue(mk(ACT_READ, 0, 0, 0));
    issue(mk(ACT_READ, 0, 0, 1));
    issue(mk(ACT_READ, 0, 0, 12'hFFF));
    issue(mk(ACT_ALLOC, 0, 0, 0));
    issue(mk(ACT_ALLOC, 1, 0, 0));
    issue(mk(ACT_ALLOC, 3, 1, 0));
    issue(mk(ACT_READ, 0, 0, 2));
    issue(mk(ACT_READ, 0, 0, 4));
    issue(mk(ACT_COUNT, 0, 0, 0));
    issue(mk(ACT_ALLOC, 12'hFFF, 0, 0));
    issue(mk(ACT_COUNT, 0, 0, 0));
    issue(mk(ACT_ALLOC, 1, 1, 0));
    issue(mk(ACT_ALLOC, 1, 0, 0));
    issue(mk(ACT_READ, 0, 0, 355));
    issue(mk(ACT_READ, 0, 0, 356));
    issue(mk(ACT_CLEAR, 0, 0, 0));
    issue(mk(ACT_COUNT, 0, 0, 0));

    // no data clusters
    wait_idle();
    configure(12'd0, 8'd0);
    issue(mk(ACT_ALLOC, 1, 0, 0));
    issue(mk(ACT_READ, 0, 0, 0));
    issue(mk(ACT_COUNT, 0, 0, 0));

    // largest disk, filled completely
    wait_idle();
    configure(12'd4084, 8'd255);
    issue(mk(ACT_READ, 0, 0, 0));
    issue(mk(ACT_ALLOC, 12'hFFF, 1, 0));
    issue(mk(ACT_COUNT, 0, 0, 0));
    issue(mk(ACT_READ, 0, 0, 4085));
    issue(mk(ACT_CLEAR, 0, 0, 0));

    for (ph = 0; ph < 12; ph++) begin
      idle_pct = (ph < 4) ? 18 : (ph < 8) ? 59 : 0;
      case (ph)
        1: span = 1;
        6: span = 0;
        9: span = 4084;
        default: begin
          if ($urandom_range(99, 0) < 70) span = $urandom_range(40, 2);
          else span = $urandom_range(300, 41);
        end
      endcase
      wait_idle();
      configure(CW'(span), 8'($urandom));
      n_items = (ph == 9) ? 20 : 82;
      for (k = 0; k < n_items; k++)
        issue(rand_cmd(span));
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (shadow.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ fat12_cluster_chain_allocator_unit.f @@
hw/rtl/fcca_pkg.sv
hw/rtl/fcca_ram.sv
hw/rtl/fcca_regs.sv
hw/rtl/fcca_seq.sv
hw/rtl/fat12_cluster_chain_allocator_unit.sv
hw/rtl/fcca_chk.sv
tb/testbench.sv
